FILE: src/drop_pkg.sv
// Package for the DHCP reply option parser: widths, option codes, types.
// Used by drop_in_reg, drop_parse and dhcp_reply_option_parser.
`default_nettype none

package drop_pkg;

    // Packet position counter
    localparam int POS_W = 10;
    localparam logic [POS_W-1:0] MAX_PACKET = 10'd548;
    localparam logic [POS_W-1:0] HDR_LEN    = 10'd240;

    // Fixed header values
    localparam logic [7:0]  OP_REPLY = 8'd2;
    localparam logic [31:0] COOKIE   = 32'h63538263;

    // Option codes
    localparam logic [7:0] OPT_PAD     = 8'd0;
    localparam logic [7:0] OPT_SUBNET  = 8'd1;
    localparam logic [7:0] OPT_ROUTER  = 8'd3;
    localparam logic [7:0] OPT_DNS     = 8'd6;
    localparam logic [7:0] OPT_LEASE   = 8'd51;
    localparam logic [7:0] OPT_MSGTYPE = 8'd53;
    localparam logic [7:0] OPT_SERVER  = 8'd54;
    localparam logic [7:0] OPT_END     = 8'd255;

    // Field store slots
    localparam int NUM_SLOTS = 7;
    localparam int NUM_OPTS  = 6;
    localparam logic [2:0] SLOT_MSGTYPE = 3'd0;
    localparam logic [2:0] SLOT_SERVER  = 3'd1;
    localparam logic [2:0] SLOT_SUBNET  = 3'd2;
    localparam logic [2:0] SLOT_ROUTER  = 3'd3;
    localparam logic [2:0] SLOT_DNS     = 3'd4;
    localparam logic [2:0] SLOT_LEASE   = 3'd5;
    localparam logic [2:0] SLOT_YIADDR  = 3'd6;
    localparam logic [2:0] SLOT_NONE    = 3'd7;

    // Value byte index meaning "not capturing"
    localparam logic [2:0] NO_CAPTURE = 3'd7;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_XID  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE = 8'd1;

    // Output word width: 202 bits of fields padded to 208
    localparam int RES_BITS = 202;
    localparam int RES_W    = 208;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    // One input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // One result
    typedef struct packed {
        logic        accepted;
        logic        header_ok;
        logic [7:0]  message_type;
        logic [31:0] your_ip;
        logic [31:0] server_id;
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_addr;
        logic [31:0] lease_seconds;
    } result_t;

    // Option code to store slot
    function automatic logic [2:0] slot_of(input logic [7:0] code);
        logic [2:0] s;
        begin
            unique case (code)
                OPT_MSGTYPE: s = SLOT_MSGTYPE;
                OPT_SERVER:  s = SLOT_SERVER;
                OPT_SUBNET:  s = SLOT_SUBNET;
                OPT_ROUTER:  s = SLOT_ROUTER;
                OPT_DNS:     s = SLOT_DNS;
                OPT_LEASE:   s = SLOT_LEASE;
                default:     s = SLOT_NONE;
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/drop_in_reg.sv
// Input register for the DHCP reply parser: holds one byte until the parser takes it.
// Depends on drop_pkg.
`default_nettype none

module drop_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire drop_pkg::in_word_t in_word,
    output logic                   word_valid,
    output drop_pkg::in_word_t     word,
    input  wire logic              word_take
);

    logic               valid_reg, valid_next;
    drop_pkg::in_word_t word_reg;

    // Free when empty or when the held word leaves this cycle
    assign in_ready   = !valid_reg || word_take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

endmodule

`default_nettype wire

FILE: src/drop_parse.sv
// Per-byte parser: header checks, option TLV walk and field capture.
// Depends on drop_pkg; fed by drop_in_reg, result registered in the top level.
`default_nettype none

module drop_parse (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire drop_pkg::in_word_t word,
    input  wire logic [31:0]        expected_xid,
    input  wire logic [7:0]         wanted_type,
    output drop_pkg::result_t       result
);

    logic [drop_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       bad_reg, bad_next;
    drop_pkg::phase_t           phase_reg, phase_next;
    logic [7:0]                 code_reg, code_next;
    logic [7:0]                 left_reg, left_next;
    logic [2:0]                 vidx_reg, vidx_next;
    logic [drop_pkg::NUM_OPTS-1:0] found_reg, found_next;
    logic [31:0]                store_reg [drop_pkg::NUM_SLOTS];
    logic [31:0]                store_next [drop_pkg::NUM_SLOTS];

    logic [7:0] b;
    logic [2:0] slot;
    logic       hdr_ok;

    assign b    = word.data_byte;
    assign slot = drop_pkg::slot_of(code_reg);

    // Next state for one byte
    always_comb
    begin
        pos_next   = pos_reg;
        bad_next   = bad_reg;
        phase_next = phase_reg;
        code_next  = code_reg;
        left_next  = left_reg;
        vidx_next  = vidx_reg;
        found_next = found_reg;
        for (int i = 0; i < drop_pkg::NUM_SLOTS; i++)
        begin
            store_next[i] = store_reg[i];
        end

        if (pos_reg < drop_pkg::MAX_PACKET)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == '0)
            begin
                if (b != drop_pkg::OP_REPLY)
                begin
                    bad_next = 1'b1;
                end
            end
            else if (pos_reg >= 10'd4 && pos_reg <= 10'd7)
            begin
                // xid compared little-endian
                if (b != expected_xid[8*pos_reg[1:0] +: 8])
                begin
                    bad_next = 1'b1;
                end
            end
            else if (pos_reg >= 10'd16 && pos_reg <= 10'd19)
            begin
                store_next[drop_pkg::SLOT_YIADDR] =
                    {store_reg[drop_pkg::SLOT_YIADDR][23:0], b};
            end
            else if (pos_reg >= 10'd236 && pos_reg <= 10'd239)
            begin
                if (b != drop_pkg::COOKIE[8*pos_reg[1:0] +: 8])
                begin
                    bad_next = 1'b1;
                end
            end
            else if (pos_reg >= drop_pkg::HDR_LEN)
            begin
                // Option TLV walk
                unique case (phase_reg)
                    drop_pkg::PH_CODE:
                    begin
                        if (b == drop_pkg::OPT_END)
                        begin
                            phase_next = drop_pkg::PH_DONE;
                        end
                        else if (b != drop_pkg::OPT_PAD)
                        begin
                            code_next  = b;
                            phase_next = drop_pkg::PH_LEN;
                        end
                    end
                    drop_pkg::PH_LEN:
                    begin
                        vidx_next = drop_pkg::NO_CAPTURE;
                        if (slot != drop_pkg::SLOT_NONE)
                        begin
                            if (!found_reg[slot])
                            begin
                                found_next[slot] = 1'b1;
                                vidx_next        = 3'd0;
                            end
                        end
                        left_next  = b;
                        phase_next = (b == 8'd0) ? drop_pkg::PH_CODE : drop_pkg::PH_VALUE;
                    end
                    drop_pkg::PH_VALUE:
                    begin
                        if (vidx_reg != drop_pkg::NO_CAPTURE && slot != drop_pkg::SLOT_NONE)
                        begin
                            if (slot == drop_pkg::SLOT_MSGTYPE)
                            begin
                                if (vidx_reg == 3'd0)
                                begin
                                    store_next[drop_pkg::SLOT_MSGTYPE] = {24'd0, b};
                                    vidx_next = vidx_reg + 3'd1;
                                end
                            end
                            else if (vidx_reg < 3'd4)
                            begin
                                // First byte lands most significant
                                store_next[slot][8*(2'd3 - vidx_reg[1:0]) +: 8] = b;
                                vidx_next = vidx_reg + 3'd1;
                            end
                        end
                        left_next = left_reg - 8'd1;
                        if (left_next == 8'd0)
                        begin
                            phase_next = drop_pkg::PH_CODE;
                        end
                    end
                    drop_pkg::PH_DONE:
                    begin
                        phase_next = drop_pkg::PH_DONE;
                    end
                    default:
                    begin
                        phase_next = drop_pkg::PH_DONE;
                    end
                endcase
            end
        end
    end

    // Result from the state after the final byte
    assign hdr_ok = (pos_next >= drop_pkg::HDR_LEN) && !bad_next;

    always_comb
    begin
        result.header_ok     = hdr_ok;
        result.message_type  = store_next[drop_pkg::SLOT_MSGTYPE][7:0];
        result.accepted      = hdr_ok &&
                               (store_next[drop_pkg::SLOT_MSGTYPE][7:0] == wanted_type);
        result.your_ip       = store_next[drop_pkg::SLOT_YIADDR];
        result.server_id     = store_next[drop_pkg::SLOT_SERVER];
        result.subnet_mask   = store_next[drop_pkg::SLOT_SUBNET];
        result.router_addr   = store_next[drop_pkg::SLOT_ROUTER];
        result.dns_addr      = store_next[drop_pkg::SLOT_DNS];
        result.lease_seconds = store_next[drop_pkg::SLOT_LEASE];
    end

    // State registers; the final byte returns everything to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            bad_reg   <= 1'b0;
            phase_reg <= drop_pkg::PH_CODE;
            code_reg  <= '0;
            left_reg  <= '0;
            vidx_reg  <= drop_pkg::NO_CAPTURE;
            found_reg <= '0;
            for (int i = 0; i < drop_pkg::NUM_SLOTS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            if (word.last_byte)
            begin
                pos_reg   <= '0;
                bad_reg   <= 1'b0;
                phase_reg <= drop_pkg::PH_CODE;
                code_reg  <= '0;
                left_reg  <= '0;
                vidx_reg  <= drop_pkg::NO_CAPTURE;
                found_reg <= '0;
                for (int i = 0; i < drop_pkg::NUM_SLOTS; i++)
                begin
                    store_reg[i] <= '0;
                end
            end
            else
            begin
                pos_reg   <= pos_next;
                bad_reg   <= bad_next;
                phase_reg <= phase_next;
                code_reg  <= code_next;
                left_reg  <= left_next;
                vidx_reg  <= vidx_next;
                found_reg <= found_next;
                for (int i = 0; i < drop_pkg::NUM_SLOTS; i++)
                begin
                    store_reg[i] <= store_next[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/dhcp_reply_option_parser.sv
// Top level of the DHCP reply option parser: config registers, result register.
// Depends on drop_pkg, drop_in_reg and drop_parse.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-----------------------------------------
//  s_axis   | in  | s_tvalid / s_tready   | tdata: data_byte; tlast: last_byte
//  m_axis   | out | m_tvalid / m_tready   | tdata: one result per packet
//  cfg      | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (0 xid, 1 type)
//
// One byte per clock sustained; a byte passes the input register, then the combinational
// parser, and the result register loads on the packet's final byte.
// Input stalls only when a final byte waits while the result register is still full.
// Reset clears all packet state and sets the config registers to their defaults.
`default_nettype none

module dhcp_reply_option_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  wire logic                           s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] accepted, [1] header_ok, [9:2] message_type, [41:10] your_ip,
    // [73:42] server_id, [105:74] subnet_mask, [137:106] router_addr,
    // [169:138] dns_addr, [201:170] lease_seconds, [207:202] zero
    output logic [drop_pkg::RES_W-1:0]          m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [drop_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    logic [31:0]        xid_reg;
    logic [7:0]         type_reg;
    logic               word_valid;
    drop_pkg::in_word_t in_word;
    drop_pkg::in_word_t word;
    logic               step;
    drop_pkg::result_t  result;
    logic               out_valid_reg, out_valid_next;
    drop_pkg::result_t  out_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xid_reg  <= 32'hDEAD1234;
            type_reg <= 8'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                drop_pkg::CFG_XID:  xid_reg  <= cfg_data;
                drop_pkg::CFG_TYPE: type_reg <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // Input register
    assign in_word.data_byte = s_tdata;
    assign in_word.last_byte = s_tlast;

    drop_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_word    (in_word),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (step)
    );

    // A final byte waits until the result register has room
    assign step = word_valid && (!word.last_byte || !out_valid_reg || m_tready);

    drop_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .word         (word),
        .expected_xid (xid_reg),
        .wanted_type  (type_reg),
        .result       (result)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && word.last_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && word.last_byte)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(drop_pkg::RES_W - drop_pkg::RES_BITS){1'b0}},
                       out_reg.lease_seconds, out_reg.dns_addr, out_reg.router_addr,
                       out_reg.subnet_mask, out_reg.server_id, out_reg.your_ip,
                       out_reg.message_type, out_reg.header_ok, out_reg.accepted};

endmodule

`default_nettype wire

FILE: tb/sv/tb_dhcp_reply_option_parser.sv
// Testbench for dhcp_reply_option_parser: streams reply packets byte by byte and
// checks every per-packet result against a byte-level predictor of the parser.
// Depends on drop_pkg and the dhcp_reply_option_parser RTL.
`default_nettype none

module tb_dhcp_reply_option_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import drop_pkg::*;

    // DUT ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;     // [7:0] data_byte
    logic                 s_tlast = 1'b0;   // last_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] accepted, [1] header_ok, [9:2] message_type, [41:10] your_ip,
    // [73:42] server_id, [105:74] subnet_mask, [137:106] router_addr,
    // [169:138] dns_addr, [201:170] lease_seconds
    logic [RES_W-1:0]     m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // Predictor copy of the configuration
    logic [31:0] xid_reg  = 32'hDEAD1234;
    logic [7:0]  type_reg = 8'd2;

    // Predictor copy of the per-packet parse state
    logic [POS_W-1:0] pos_count;
    logic             hdr_bad;
    phase_t           opt_phase;
    logic [7:0]       opt_code;
    logic [7:0]       opt_left;
    logic [2:0]       val_idx;
    logic [5:0]       found_mask;
    logic [31:0]      field_val [0:NUM_SLOTS-1];

    result_t     pending_results[$];
    logic [7:0]  pkt_bytes[$];

    int traffic_mode = 1;   // 0 no idling, 1 light, 2 heavy
    int errors = 0;
    int packets_sent = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int accepted_seen = 0;

    dhcp_reply_option_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Option code to capture slot
    function automatic logic [2:0] slot_for_code(input logic [7:0] code);
        case (code)
            OPT_MSGTYPE: return SLOT_MSGTYPE;
            OPT_SERVER:  return SLOT_SERVER;
            OPT_SUBNET:  return SLOT_SUBNET;
            OPT_ROUTER:  return SLOT_ROUTER;
            OPT_DNS:     return SLOT_DNS;
            OPT_LEASE:   return SLOT_LEASE;
            default:     return SLOT_NONE;
        endcase
    endfunction

    function void clear_packet_state();
        pos_count  = '0;
        hdr_bad    = 1'b0;
        opt_phase  = PH_CODE;
        opt_code   = '0;
        opt_left   = '0;
        val_idx    = NO_CAPTURE;
        found_mask = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            field_val[i] = '0;
    endfunction

    // TLV walker, one byte past the fixed header
    function void walk_option(input logic [7:0] d);
        logic [2:0] slot;
        case (opt_phase)
            PH_CODE:
            begin
                if (d == OPT_END)
                    opt_phase = PH_DONE;
                else if (d != OPT_PAD)
                begin
                    opt_code  = d;
                    opt_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                // only the first occurrence of an option is captured
                slot    = slot_for_code(opt_code);
                val_idx = NO_CAPTURE;
                if (slot != SLOT_NONE && !found_mask[slot])
                begin
                    found_mask[slot] = 1'b1;
                    val_idx = 3'd0;
                end
                opt_left = d;
                if (d == 8'd0)
                    opt_phase = PH_CODE;
                else
                    opt_phase = PH_VALUE;
            end
            PH_VALUE:
            begin
                slot = slot_for_code(opt_code);
                if (val_idx != NO_CAPTURE && slot != SLOT_NONE)
                begin
                    if (slot == SLOT_MSGTYPE)
                    begin
                        if (val_idx < 3'd1)
                        begin
                            field_val[SLOT_MSGTYPE] = {24'd0, d};
                            val_idx = val_idx + 3'd1;
                        end
                    end
                    else if (val_idx < 3'd4)
                    begin
                        field_val[slot][8*(3-val_idx) +: 8] = d;
                        val_idx = val_idx + 3'd1;
                    end
                end
                opt_left = opt_left - 8'd1;
                if (opt_left == 8'd0)
                    opt_phase = PH_CODE;
            end
            default: ;
        endcase
    endfunction

    // Predict the effect of one accepted byte; queue a result on the final byte
    function void parse_byte(input logic [7:0] d, input logic last);
        result_t r;
        if (pos_count < MAX_PACKET)
        begin
            if (pos_count == 0)
            begin
                if (d != OP_REPLY)
                    hdr_bad = 1'b1;
            end
            else if (pos_count >= 4 && pos_count <= 7)
            begin
                if (d != xid_reg[8*(pos_count-4) +: 8])
                    hdr_bad = 1'b1;
            end
            else if (pos_count >= 16 && pos_count <= 19)
                field_val[SLOT_YIADDR] = {field_val[SLOT_YIADDR][23:0], d};
            else if (pos_count >= 236 && pos_count <= 239)
            begin
                if (d != COOKIE[8*(pos_count-236) +: 8])
                    hdr_bad = 1'b1;
            end
            else if (pos_count >= HDR_LEN)
                walk_option(d);
            pos_count = pos_count + 1'b1;
        end
        if (last)
        begin
            r.header_ok     = (pos_count >= HDR_LEN) && !hdr_bad;
            r.message_type  = field_val[SLOT_MSGTYPE][7:0];
            r.accepted      = r.header_ok && (r.message_type == type_reg);
            r.your_ip       = field_val[SLOT_YIADDR];
            r.server_id     = field_val[SLOT_SERVER];
            r.subnet_mask   = field_val[SLOT_SUBNET];
            r.router_addr   = field_val[SLOT_ROUTER];
            r.dns_addr      = field_val[SLOT_DNS];
            r.lease_seconds = field_val[SLOT_LEASE];
            pending_results.push_back(r);
            clear_packet_state();
        end
    endfunction

    // Packet building
    function void start_header(input logic [7:0] op, input logic [31:0] xid,
                               input logic [31:0] yip);
        pkt_bytes.delete();
        for (int i = 0; i < HDR_LEN; i++)
            pkt_bytes.push_back($urandom_range(0, 255));
        pkt_bytes[0] = op;
        for (int i = 0; i < 4; i++)
        begin
            pkt_bytes[4+i]   = xid[8*i +: 8];
            pkt_bytes[16+i]  = yip[31-8*i -: 8];
            pkt_bytes[236+i] = COOKIE[8*i +: 8];
        end
    endfunction

    // value bytes beyond the fourth are random
    function void add_opt(input logic [7:0] code, input int len, input logic [31:0] val);
        pkt_bytes.push_back(code);
        pkt_bytes.push_back(len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            if (i < 4)
                pkt_bytes.push_back(val[31-8*i -: 8]);
            else
                pkt_bytes.push_back($urandom_range(0, 255));
        end
    endfunction

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (traffic_mode == 0)
            return 0;
        if (r < ((traffic_mode == 2) ? 45 : 75))
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function int pick_len(input int usual);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return usual;
        if (r < 97)
            return $urandom_range(0, 8);
        return $urandom_range(9, 255);
    endfunction

    // Send one byte and run the predictor when it is taken
    task send_byte(input logic [7:0] d, input logic last);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        parse_byte(d, last);
        bytes_sent++;
    endtask

    task send_packet();
        int n;
        n = pkt_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(pkt_bytes[i], i == n - 1);
        packets_sent++;
    endtask

    // Write both registers once the parser has drained
    task set_config(input logic [31:0] xid, input logic [7:0] wanted);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_XID;
        cfg_data  <= xid;
        do
            @(posedge clk);
        while (!cfg_ready);
        xid_reg = xid;
        cfg_index <= CFG_TYPE;
        cfg_data  <= {24'd0, wanted};
        do
            @(posedge clk);
        while (!cfg_ready);
        type_reg = wanted;
        cfg_valid <= 1'b0;
    endtask

    // Reset values of the registers, full offer with every option
    task test_default_config();
        start_header(OP_REPLY, xid_reg, 32'hC0A8010A);
        add_opt(OPT_MSGTYPE, 1, {type_reg, 24'd0});
        add_opt(OPT_SERVER, 4, 32'hC0A80101);
        add_opt(OPT_SUBNET, 4, 32'hFFFFFF00);
        add_opt(OPT_ROUTER, 4, 32'hC0A801FE);
        add_opt(OPT_DNS, 4, 32'h08080808);
        add_opt(OPT_LEASE, 4, 32'h00015180);
        pkt_bytes.push_back(OPT_END);
        send_packet();
    endtask

    // op, xid, cookie and length checks; fields are still reported
    task test_header_checks();
        start_header(8'd1, xid_reg, $urandom);
        add_opt(OPT_MSGTYPE, 1, {type_reg, 24'd0});
        add_opt(OPT_ROUTER, 4, $urandom);
        send_packet();
        start_header(OP_REPLY, xid_reg, $urandom);
        pkt_bytes[6] = pkt_bytes[6] ^ 8'h01;
        add_opt(OPT_MSGTYPE, 1, {type_reg, 24'd0});
        send_packet();
        start_header(OP_REPLY, xid_reg, $urandom);
        pkt_bytes[238] = pkt_bytes[238] ^ 8'h80;
        add_opt(OPT_MSGTYPE, 1, {type_reg, 24'd0});
        send_packet();
        // header only, exactly the minimum length
        start_header(OP_REPLY, xid_reg, 32'hFFFFFFFF);
        send_packet();
        // one byte short of a header
        start_header(OP_REPLY, xid_reg, $urandom);
        void'(pkt_bytes.pop_back());
        send_packet();
        pkt_bytes.delete();
        pkt_bytes.push_back(OP_REPLY);
        send_packet();
    endtask

    task test_option_cases();
        // short and long values, pads, message type longer than one byte
        start_header(OP_REPLY, xid_reg, $urandom);
        pkt_bytes.push_back(OPT_PAD);
        add_opt(OPT_MSGTYPE, 3, {type_reg, 16'hABCD, 8'd0});
        add_opt(OPT_SERVER, 2, 32'hA1B2C3D4);
        pkt_bytes.push_back(OPT_PAD);
        add_opt(OPT_SUBNET, 1, 32'hFF000000);
        add_opt(OPT_ROUTER, 6, 32'h0A000001);
        add_opt(OPT_DNS, 3, 32'h01020304);
        add_opt(OPT_LEASE, 0, 32'h0);
        add_opt(OPT_LEASE, 4, 32'h12345678);
        pkt_bytes.push_back(OPT_END);
        send_packet();
        // repeated options: first wins
        start_header(OP_REPLY, xid_reg, $urandom);
        add_opt(OPT_MSGTYPE, 1, {type_reg, 24'd0});
        add_opt(OPT_ROUTER, 4, 32'h11111111);
        add_opt(OPT_MSGTYPE, 1, {type_reg + 8'd1, 24'd0});
        add_opt(OPT_ROUTER, 4, 32'h22222222);
        pkt_bytes.push_back(OPT_END);
        send_packet();
        // empty message type counts as found
        start_header(OP_REPLY, xid_reg, $urandom);
        add_opt(OPT_MSGTYPE, 0, 32'h0);
        add_opt(OPT_MSGTYPE, 1, {type_reg, 24'd0});
        send_packet();
        // options after end are ignored
        start_header(OP_REPLY, xid_reg, $urandom);
        add_opt(OPT_DNS, 4, $urandom);
        pkt_bytes.push_back(OPT_END);
        add_opt(OPT_SERVER, 4, $urandom);
        add_opt(OPT_MSGTYPE, 1, {type_reg, 24'd0});
        send_packet();
        // unknown option with maximum length hides what it covers
        start_header(OP_REPLY, xid_reg, $urandom);
        add_opt(8'd200, 255, {OPT_MSGTYPE, 8'd1, type_reg, 8'd0});
        add_opt(OPT_SUBNET, 4, $urandom);
        send_packet();
        // packet ends in the middle of a value
        start_header(OP_REPLY, xid_reg, $urandom);
        add_opt(OPT_LEASE, 4, 32'hCAFEF00D);
        void'(pkt_bytes.pop_back());
        void'(pkt_bytes.pop_back());
        send_packet();
        // packet ends on an option code
        start_header(OP_REPLY, xid_reg, $urandom);
        add_opt(OPT_SERVER, 4, $urandom);
        pkt_bytes.push_back(OPT_LEASE);
        send_packet();
    endtask

    // Bytes past the maximum packet size are ignored
    task test_oversize();
        start_header(OP_REPLY, xid_reg, $urandom);
        add_opt(OPT_MSGTYPE, 1, {type_reg, 24'd0});
        while (pkt_bytes.size() < MAX_PACKET - 2)
            pkt_bytes.push_back(OPT_PAD);
        add_opt(OPT_SERVER, 4, 32'h55667788);
        while (pkt_bytes.size() < 600)
            pkt_bytes.push_back($urandom_range(0, 255));
        send_packet();
    endtask

    task test_config_extremes();
        set_config(32'h00000000, 8'd0);
        // no message type at all matches a wanted type of zero
        start_header(OP_REPLY, xid_reg, 32'h00000000);
        add_opt(OPT_SERVER, 4, $urandom);
        pkt_bytes.push_back(OPT_END);
        send_packet();
        start_header(OP_REPLY, xid_reg, $urandom);
        add_opt(OPT_MSGTYPE, 0, 32'h0);
        send_packet();
        set_config(32'hFFFFFFFF, 8'd255);
        start_header(OP_REPLY, xid_reg, 32'hFFFFFFFF);
        add_opt(OPT_MSGTYPE, 1, 32'hFF000000);
        add_opt(OPT_LEASE, 4, 32'hFFFFFFFF);
        send_packet();
        start_header(OP_REPLY, xid_reg, $urandom);
        add_opt(OPT_MSGTYPE, 1, 32'h05000000);
        send_packet();
    endtask

    // Mostly well-formed replies with random content, some noise and damage
    task rand_packet();
        logic [7:0] addr_codes [5];
        logic [7:0] mtype;
        int         r;
        int         n;
        int         k;
        addr_codes = '{OPT_SERVER, OPT_SUBNET, OPT_ROUTER, OPT_DNS, OPT_LEASE};
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            pkt_bytes.delete();
            n = $urandom_range(1, 300);
            repeat (n) pkt_bytes.push_back($urandom_range(0, 255));
            if ($urandom_range(0, 1))
                pkt_bytes[0] = OP_REPLY;
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                start_header($urandom_range(0, 255), xid_reg, $urandom);
            else
                start_header(OP_REPLY, xid_reg, $urandom);
            if ($urandom_range(0, 9) == 0)
                pkt_bytes[$urandom_range(4, 7)] ^= 8'd1 << $urandom_range(0, 7);
            if ($urandom_range(0, 9) == 0)
                pkt_bytes[$urandom_range(236, 239)] ^= 8'd1 << $urandom_range(0, 7);
            n = $urandom_range(0, 9);
            repeat (n)
            begin
                k = $urandom_range(0, 9);
                mtype = ($urandom_range(0, 3) != 0) ? type_reg : 8'($urandom_range(0, 255));
                case (k)
                    0:       pkt_bytes.push_back(OPT_PAD);
                    1:       add_opt(OPT_MSGTYPE, pick_len(1), {mtype, 24'd0});
                    2, 3, 4, 5, 6:
                             add_opt(addr_codes[k-2], pick_len(4), $urandom);
                    default: add_opt($urandom_range(1, 254), pick_len(4), $urandom);
                endcase
            end
            if ($urandom_range(0, 4) != 0)
            begin
                pkt_bytes.push_back(OPT_END);
                repeat ($urandom_range(0, 10)) pkt_bytes.push_back($urandom_range(0, 255));
            end
            // cut short inside the options
            if ($urandom_range(0, 9) == 0 && pkt_bytes.size() > HDR_LEN + 1)
            begin
                n = $urandom_range(HDR_LEN + 1, pkt_bytes.size() - 1);
                pkt_bytes = pkt_bytes[0:n-1];
            end
            // run past the maximum size
            if ($urandom_range(0, 19) == 0)
            begin
                n = $urandom_range(MAX_PACKET + 1, 640);
                while (pkt_bytes.size() < n)
                    pkt_bytes.push_back($urandom_range(0, 255));
            end
        end
        send_packet();
    endtask

    task test_random();
        logic [7:0] wanted;
        for (int ph = 0; ph < 4; ph++)
        begin
            case ($urandom_range(0, 2))
                0:       wanted = 8'd2;
                1:       wanted = 8'd5;
                default: wanted = $urandom_range(0, 255);
            endcase
            set_config($urandom, wanted);
            traffic_mode = ph % 3;
            repeat (14) rand_packet();
        end
    endtask

    // Receiver stalls
    initial
    begin : sink_stall
        int r;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (traffic_mode == 0 || r < ((traffic_mode == 2) ? 50 : 80))
                m_tready <= 1'b1;
            else if (r < 96)
                m_tready <= 1'b0;
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 30)) @(posedge clk);
            end
        end
    end

    task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %08h, actual %08h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.accepted      = m_tdata[0];
            got.header_ok     = m_tdata[1];
            got.message_type  = m_tdata[9:2];
            got.your_ip       = m_tdata[41:10];
            got.server_id     = m_tdata[73:42];
            got.subnet_mask   = m_tdata[105:74];
            got.router_addr   = m_tdata[137:106];
            got.dns_addr      = m_tdata[169:138];
            got.lease_seconds = m_tdata[201:170];
            results_seen++;
            if (got.accepted)
                accepted_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none expected, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("accepted", want.accepted, got.accepted);
                check_field("header_ok", want.header_ok, got.header_ok);
                check_field("message_type", want.message_type, got.message_type);
                check_field("your_ip", want.your_ip, got.your_ip);
                check_field("server_id", want.server_id, got.server_id);
                check_field("subnet_mask", want.subnet_mask, got.subnet_mask);
                check_field("router_addr", want.router_addr, got.router_addr);
                check_field("dns_addr", want.dns_addr, got.dns_addr);
                check_field("lease_seconds", want.lease_seconds, got.lease_seconds);
            end
        end
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("tb_dhcp_reply_option_parser: errors");
        $finish;
    end

    // Test sequence
    initial
    begin
        clear_packet_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_default_config();
        test_header_checks();
        test_option_cases();
        test_oversize();
        test_config_extremes();
        test_random();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            errors++;
        $display("Ran %0d packets (%0d bytes), %0d results checked, %0d accepted;",
                 packets_sent, bytes_sent, results_seen, accepted_seen);
        $display("covered header faults, short, cut and oversize packets, register extremes.");
        if (errors == 0)
            $display("tb_dhcp_reply_option_parser: clean");
        else
            $display("tb_dhcp_reply_option_parser: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
src/drop_pkg.sv
src/drop_in_reg.sv
src/drop_parse.sv
src/dhcp_reply_option_parser.sv
tb/sv/tb_dhcp_reply_option_parser.sv
